// ===== hw/rtl/lca_pkg.sv =====
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types, codes and microcode addresses of the binary-lifting LCA engine.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int NODE_W  = 10;
    localparam int STEPS_W = 10;
    localparam int TIME_W  = 12;
    localparam int PC_W    = 5;

    localparam int DEF_NODES  = 1024;
    localparam int DEF_LEVELS = 11;

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_LEAVE = 2'd1,
        REQ_LCA   = 2'd2,
        REQ_JUMP  = 2'd3
    } lca_req_kind_t;

    typedef struct packed {
        lca_req_kind_t       req_type;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [STEPS_W-1:0]  steps;
    } lca_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] answer_node;
        logic              answer_kind;
    } lca_rsp_t;

    // Datapath actions, one per microcode step
    typedef enum logic [4:0] {
        ACT_IDLE,
        ACT_STAMP_ENTRY,
        ACT_ANC_RD_CUR,
        ACT_ANC_FILL,
        ACT_STAMP_EXIT,
        ACT_TIME_RD_B,
        ACT_TIME_RD_A,
        ACT_TEST_ENDS,
        ACT_ANC_RD_U,
        ACT_TIME_RD_W,
        ACT_CLIMB_TEST,
        ACT_RES_ANC,
        ACT_EMIT,
        ACT_JUMP_INIT,
        ACT_REP_TAKE,
        ACT_BIT_INIT,
        ACT_BIT_TAKE,
        ACT_RES_U
    } lca_act_t;

    typedef enum logic [2:0] {
        CND_ALWAYS,
        CND_DISPATCH,
        CND_LVL_MORE,
        CND_HIT,
        CND_LVL_NZ,
        CND_REP_ZERO,
        CND_BIT_MORE,
        CND_OUT_FREE
    } lca_cond_t;

    typedef struct packed {
        lca_act_t         act;
        lca_cond_t        cond;
        logic [PC_W-1:0]  tgt;  // taken when the condition holds
        logic [PC_W-1:0]  alt;  // taken otherwise
    } lca_uword_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic lvl_top;
        logic lvl_zero;
        logic lvl_bit_last;
        logic hit;
        logic rep_zero;
    } lca_stat_t;

    // Microcode addresses
    localparam logic [PC_W-1:0] P_IDLE = 5'd0;
    localparam logic [PC_W-1:0] P_E0   = 5'd1;
    localparam logic [PC_W-1:0] P_E1   = 5'd2;
    localparam logic [PC_W-1:0] P_E2   = 5'd3;
    localparam logic [PC_W-1:0] P_L0   = 5'd4;
    localparam logic [PC_W-1:0] P_Q0   = 5'd5;
    localparam logic [PC_W-1:0] P_Q1   = 5'd6;
    localparam logic [PC_W-1:0] P_Q2   = 5'd7;
    localparam logic [PC_W-1:0] P_Q3   = 5'd8;
    localparam logic [PC_W-1:0] P_Q4   = 5'd9;
    localparam logic [PC_W-1:0] P_Q5   = 5'd10;
    localparam logic [PC_W-1:0] P_Q6   = 5'd11;
    localparam logic [PC_W-1:0] P_Q7   = 5'd12;
    localparam logic [PC_W-1:0] P_EMIT = 5'd13;
    localparam logic [PC_W-1:0] P_J0   = 5'd14;
    localparam logic [PC_W-1:0] P_J1   = 5'd15;
    localparam logic [PC_W-1:0] P_J2   = 5'd16;
    localparam logic [PC_W-1:0] P_J3   = 5'd17;
    localparam logic [PC_W-1:0] P_J4   = 5'd18;
    localparam logic [PC_W-1:0] P_J5   = 5'd19;
    localparam logic [PC_W-1:0] P_J6   = 5'd20;

    // Reduce a node number modulo the node count by shifted compare-subtract
    function automatic logic [NODE_W-1:0] node_wrap(input logic [NODE_W-1:0] v,
                                                    input int unsigned nodes);
        logic [31:0] r;
        logic [31:0] m;
        r = 32'(v);
        for (int j = NODE_W - 1; j >= 0; j--) begin
            m = 32'(nodes) << j;
            if (r >= m) begin
                r = r - m;
            end
        end
        return NODE_W'(r);
    endfunction

endpackage

// ===== hw/rtl/lca_ram.sv =====
// ----------------------------------------------------------------------------
// lca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lca_seq.sv =====
// ----------------------------------------------------------------------------
// lca_seq
// Microcode sequencer: control ROM, step counter and conditional branching.
// ----------------------------------------------------------------------------
module lca_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  lca_pkg::lca_req_kind_t req_type,
    input  logic                   out_free,
    input  lca_pkg::lca_stat_t     stat,
    output lca_pkg::lca_act_t      act
);
    import lca_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    lca_uword_t      uw;
    logic            cond_ok;
    logic [PC_W-1:0] entry_pc;

    function automatic lca_uword_t ucode(input logic [PC_W-1:0] pc);
        lca_uword_t w;
        w = '{act: ACT_IDLE, cond: CND_DISPATCH, tgt: P_IDLE, alt: P_IDLE};
        case (pc)
            P_IDLE: w = '{ACT_IDLE,        CND_DISPATCH, P_IDLE, P_IDLE};
            P_E0:   w = '{ACT_STAMP_ENTRY, CND_ALWAYS,   P_E1,   P_E1};
            P_E1:   w = '{ACT_ANC_RD_CUR,  CND_ALWAYS,   P_E2,   P_E2};
            P_E2:   w = '{ACT_ANC_FILL,    CND_LVL_MORE, P_E1,   P_IDLE};
            P_L0:   w = '{ACT_STAMP_EXIT,  CND_ALWAYS,   P_IDLE, P_IDLE};
            P_Q0:   w = '{ACT_TIME_RD_B,   CND_ALWAYS,   P_Q1,   P_Q1};
            P_Q1:   w = '{ACT_TIME_RD_A,   CND_ALWAYS,   P_Q2,   P_Q2};
            P_Q2:   w = '{ACT_TEST_ENDS,   CND_HIT,      P_EMIT, P_Q3};
            P_Q3:   w = '{ACT_ANC_RD_U,    CND_ALWAYS,   P_Q4,   P_Q4};
            P_Q4:   w = '{ACT_TIME_RD_W,   CND_ALWAYS,   P_Q5,   P_Q5};
            P_Q5:   w = '{ACT_CLIMB_TEST,  CND_LVL_NZ,   P_Q3,   P_Q6};
            P_Q6:   w = '{ACT_ANC_RD_U,    CND_ALWAYS,   P_Q7,   P_Q7};
            P_Q7:   w = '{ACT_RES_ANC,     CND_ALWAYS,   P_EMIT, P_EMIT};
            P_EMIT: w = '{ACT_EMIT,        CND_OUT_FREE, P_IDLE, P_EMIT};
            P_J0:   w = '{ACT_JUMP_INIT,   CND_ALWAYS,   P_J1,   P_J1};
            P_J1:   w = '{ACT_ANC_RD_U,    CND_REP_ZERO, P_J3,   P_J2};
            P_J2:   w = '{ACT_REP_TAKE,    CND_ALWAYS,   P_J1,   P_J1};
            P_J3:   w = '{ACT_BIT_INIT,    CND_ALWAYS,   P_J4,   P_J4};
            P_J4:   w = '{ACT_ANC_RD_U,    CND_ALWAYS,   P_J5,   P_J5};
            P_J5:   w = '{ACT_BIT_TAKE,    CND_BIT_MORE, P_J4,   P_J6};
            P_J6:   w = '{ACT_RES_U,       CND_ALWAYS,   P_EMIT, P_EMIT};
            default: w = '{ACT_IDLE,       CND_ALWAYS,   P_IDLE, P_IDLE};
        endcase
        return w;
    endfunction

    assign uw  = ucode(pc_reg);
    assign act = uw.act;

    always_comb begin
        unique case (req_type)
            REQ_ENTER: entry_pc = P_E0;
            REQ_LEAVE: entry_pc = P_L0;
            REQ_LCA:   entry_pc = P_Q0;
            REQ_JUMP:  entry_pc = P_J0;
            default:   entry_pc = P_IDLE;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            CND_ALWAYS:   cond_ok = 1'b1;
            CND_DISPATCH: cond_ok = in_valid;
            CND_LVL_MORE: cond_ok = !stat.lvl_top;
            CND_HIT:      cond_ok = stat.hit;
            CND_LVL_NZ:   cond_ok = !stat.lvl_zero;
            CND_REP_ZERO: cond_ok = stat.rep_zero;
            CND_BIT_MORE: cond_ok = !stat.lvl_bit_last;
            CND_OUT_FREE: cond_ok = out_free;
            default:      cond_ok = 1'b1;
        endcase
    end

    always_comb begin
        if (uw.cond == CND_DISPATCH) begin
            pc_next = cond_ok ? entry_pc : P_IDLE;
        end else begin
            pc_next = cond_ok ? uw.tgt : uw.alt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= P_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/lca_dp.sv =====
// ----------------------------------------------------------------------------
// lca_dp
// Datapath: ancestor and time RAMs, working registers and ancestor test.
// ----------------------------------------------------------------------------
module lca_dp #(
    parameter int NODES  = lca_pkg::DEF_NODES,
    parameter int LEVELS = lca_pkg::DEF_LEVELS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lca_pkg::lca_act_t   act,
    input  logic                accept,
    input  lca_pkg::lca_req_t   req,
    output lca_pkg::lca_stat_t  stat,
    output lca_pkg::lca_rsp_t   rsp
);
    import lca_pkg::*;

    localparam int NW        = $clog2(NODES);
    localparam int LW        = $clog2(LEVELS);
    localparam int ANC_DEPTH = NODES << LW;
    localparam int AW        = NW + LW;
    localparam logic [LW-1:0] LVL_TOP      = LW'(LEVELS - 1);
    localparam logic [LW-1:0] LVL_BIT_LAST = LW'(LEVELS - 2);

    logic [NW-1:0]      a_reg, b_reg, u_reg, w_reg, cur_reg, res_reg;
    logic [STEPS_W-1:0] k_reg, rep_reg;
    logic [LW-1:0]      lvl_reg;
    logic [TIME_W-1:0]  ev_reg, xv_reg;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic               kind_reg;

    logic [NW-1:0]      a_in, b_in;
    logic               anc_we;
    logic [AW-1:0]      anc_waddr, anc_raddr;
    logic [NW-1:0]      anc_wdata, anc_rd;
    logic               ent_we, ext_we;
    logic [NW-1:0]      tm_raddr;
    logic [TIME_W-1:0]  ent_rd, ext_rd;
    logic               above_x, above_v, step_bit;

    assign a_in      = NW'(node_wrap(req.node_a, NODES));
    assign b_in      = NW'(node_wrap(req.node_b, NODES));
    assign time_next = time_reg + TIME_W'(1);

    // Ancestor test of the node whose times are on the read port against v
    assign above_x  = (ent_rd <= ev_reg) && (xv_reg <= ext_rd);
    assign above_v  = (ev_reg <= ent_rd) && (ext_rd <= xv_reg);
    assign step_bit = |((STEPS_W'(1) << lvl_reg) & k_reg);

    assign stat.lvl_top      = (lvl_reg == LVL_TOP);
    assign stat.lvl_zero     = (lvl_reg == '0);
    assign stat.lvl_bit_last = (lvl_reg == LVL_BIT_LAST);
    assign stat.hit          = above_x || above_v;
    assign stat.rep_zero     = (rep_reg == '0);

    assign rsp.answer_node = NODE_W'(res_reg);
    assign rsp.answer_kind = kind_reg;

    always_comb begin
        anc_we    = 1'b0;
        anc_waddr = {a_reg, LW'(0)};
        anc_wdata = b_reg;
        anc_raddr = {u_reg, lvl_reg};
        ent_we    = 1'b0;
        ext_we    = 1'b0;
        tm_raddr  = u_reg;
        case (act)
            ACT_STAMP_ENTRY: begin
                anc_we = 1'b1;
                ent_we = 1'b1;
            end
            ACT_ANC_RD_CUR:  anc_raddr = {cur_reg, lvl_reg - LW'(1)};
            ACT_ANC_FILL: begin
                anc_we    = 1'b1;
                anc_waddr = {a_reg, lvl_reg};
                anc_wdata = anc_rd;
            end
            ACT_STAMP_EXIT:  ext_we = 1'b1;
            ACT_TIME_RD_B:   tm_raddr = b_reg;
            ACT_TIME_RD_W:   tm_raddr = anc_rd;
            default: ;
        endcase
    end

    lca_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc_ram (
        .aclk    (aclk),
        .wr_en   (anc_we),
        .wr_addr (anc_waddr),
        .wr_data (anc_wdata),
        .rd_addr (anc_raddr),
        .rd_data (anc_rd)
    );

    lca_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (a_reg),
        .wr_data (time_next),
        .rd_addr (tm_raddr),
        .rd_data (ent_rd)
    );

    lca_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_exit_ram (
        .aclk    (aclk),
        .wr_en   (ext_we),
        .wr_addr (a_reg),
        .wr_data (time_next),
        .rd_addr (tm_raddr),
        .rd_data (ext_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (act == ACT_STAMP_ENTRY || act == ACT_STAMP_EXIT) begin
            time_reg <= time_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            u_reg    <= a_in;
            k_reg    <= req.steps;
            kind_reg <= (req.req_type == REQ_JUMP);
        end
        case (act)
            ACT_STAMP_ENTRY: begin
                cur_reg <= b_reg;
                lvl_reg <= LW'(1);
            end
            ACT_ANC_FILL: begin
                cur_reg <= anc_rd;
                lvl_reg <= lvl_reg + LW'(1);
            end
            ACT_TIME_RD_A: begin
                ev_reg <= ent_rd;
                xv_reg <= ext_rd;
            end
            ACT_TEST_ENDS: begin
                res_reg <= above_x ? u_reg : b_reg;
                lvl_reg <= LVL_TOP;
            end
            ACT_TIME_RD_W:   w_reg <= anc_rd;
            ACT_CLIMB_TEST: begin
                if (!above_x) begin
                    u_reg <= w_reg;
                end
                // hold level zero for the final parent read
                if (lvl_reg != '0) begin
                    lvl_reg <= lvl_reg - LW'(1);
                end
            end
            ACT_RES_ANC:     res_reg <= anc_rd;
            ACT_JUMP_INIT: begin
                rep_reg <= k_reg >> (LEVELS - 1);
                lvl_reg <= LVL_TOP;
            end
            ACT_REP_TAKE: begin
                u_reg   <= anc_rd;
                rep_reg <= rep_reg - STEPS_W'(1);
            end
            ACT_BIT_INIT:    lvl_reg <= '0;
            ACT_BIT_TAKE: begin
                if (step_bit) begin
                    u_reg <= anc_rd;
                end
                lvl_reg <= lvl_reg + LW'(1);
            end
            ACT_RES_U:       res_reg <= u_reg;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/tree_lca_binary_lifting.sv =====
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Binary-lifting lowest common ancestor and k-th ancestor engine.
// ----------------------------------------------------------------------------
// The host walks the tree depth first and sends one request per transfer on
// the s_ channel: enter (node, parent; the root names itself), leave, lca
// query or jump query. Enter and leave produce no result; each query produces
// one transfer on the m_ channel with the answer node and its kind.
// Requests are handled one at a time by a microcoded sequencer; s_ready is
// high only while it waits at its dispatch step. An lca query finishes early
// if one node is above the other. Request time is set by the single read
// port of the ancestor RAM: every level is a dependent read of registered
// read data, and an lca level adds a time-stamp read after it. A finished
// result sits in an output register; if the receiver stalls the sequencer
// holds at its emit step until the register frees, and nothing is lost.
// Reset clears the sequencer, the output valid and the time counter; table
// contents are left as they are. A node must be entered before it is read;
// the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting #(
    parameter int NODES  = lca_pkg::DEF_NODES,
    parameter int LEVELS = lca_pkg::DEF_LEVELS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lca_pkg::lca_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lca_pkg::lca_rsp_t m_data
);
    import lca_pkg::*;

    lca_act_t  act;
    lca_stat_t stat;
    lca_rsp_t  rsp;
    lca_rsp_t  m_data_reg;
    logic      m_valid_reg;
    logic      out_free;
    logic      emit;
    logic      accept;

    assign s_ready  = (act == ACT_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (act == ACT_EMIT) && out_free;

    lca_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .req_type (s_data.req_type),
        .out_free (out_free),
        .stat     (stat),
        .act      (act)
    );

    lca_dp #(.NODES(NODES), .LEVELS(LEVELS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .act     (act),
        .accept  (accept),
        .req     (s_data),
        .stat    (stat),
        .rsp     (rsp)
    );

    // Output register: load on emit, drop once the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
